// ----- rtl/core/amdma_pkg.sv -----
// Shared constants and register codes of the motion detector with moving average.
package amdma_pkg;

  localparam int WINDOW_MAX_DEF = 255;
  localparam int TIMER_BITS_DEF = 24;

  localparam int SAMPLE_W = 12;
  localparam int TICK_W   = 24;
  localparam int THR_W    = 12;
  localparam int TPM_W    = 16;
  localparam int CNT_W    = 8;

  localparam int IN_DATA_W       = 64;
  localparam int OUT_DATA_W      = 64;
  localparam int OUT_USER_W      = 1;
  localparam int OUT_ELAPSED_LSB = 3 * SAMPLE_W;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [TICK_W-1:0] ELAPSED_MAX = '1;

  typedef enum logic [2:0] {
    REG_THR_X    = 3'd0,
    REG_THR_Y    = 3'd1,
    REG_THR_Z    = 3'd2,
    REG_DEBOUNCE = 3'd3,
    REG_TPM      = 3'd4,
    REG_DET_EN   = 3'd5,
    REG_AVG_EN   = 3'd6,
    REG_AVG_CNT  = 3'd7
  } reg_idx_t;

endpackage

// ----- rtl/core/accel_motion_detect_moving_avg_top.sv -----
// Top level of the three-axis motion detector with moving-average window.
//
// Usage:
//   in_*  : one accelerometer sample per transfer (x, y, z in milli-g and the
//           timer value at sample time). in_tready is high only while the
//           block is idle; one sample is worked on at a time.
//   out_* : one result per sample: window averages of x, y, z, the elapsed
//           milliseconds since the last movement, and the movement flag in
//           tuser. The result sits in an output register until taken.
//   cfg_* : APB register port, one 32-bit register every 4 bytes. Write only
//           while no sample is in flight. pready is tied high.
// Flow: the window sum reads one entry a cycle from the window memory, then one
//   bit-serial divider produces one quotient bit a cycle for the three averages
//   and the elapsed time in turn. A new sample is taken only once the result of
//   the last one has been loaded into the output register.
// Reset: registers take their reset values and the per-entry valid bits of the
//   window clear at once, so the window reads as all zero; no clearing pass.
// Stall: a result not taken holds the output; the next result waits in the
//   final step until the output register frees, and no new sample is taken.
module accel_motion_detect_moving_avg_top #(
  parameter int WINDOW_MAX = amdma_pkg::WINDOW_MAX_DEF,
  parameter int TIMER_BITS = amdma_pkg::TIMER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // sample_x[11:0], sample_y[23:12], sample_z[35:24], now_ticks[59:36], zero pad
  input  logic [amdma_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // avg_x[11:0], avg_y[23:12], avg_z[35:24], elapsed_ms[59:36], zero pad
  output logic [amdma_pkg::OUT_DATA_W-1:0]    out_tdata,
  // movement[0]
  output logic [amdma_pkg::OUT_USER_W-1:0]    out_tuser,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [amdma_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [amdma_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [amdma_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                cfg_pready
);
  import amdma_pkg::*;

  localparam int AW     = $clog2(WINDOW_MAX);
  localparam int CW     = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W  = SAMPLE_W + CW;
  localparam int NOW_W  = (TIMER_BITS < TICK_W) ? TIMER_BITS : TICK_W;
  localparam int CMP_W  = (TIMER_BITS > TICK_W) ? TIMER_BITS : TICK_W;
  localparam int DW     = (TIMER_BITS > SUM_W) ? TIMER_BITS : SUM_W;
  localparam int QW     = (DW > TICK_W) ? DW : TICK_W;
  localparam int BIT_W  = $clog2(DW);
  localparam int MEM_W  = 3 * SAMPLE_W;
  localparam int PAD_W  = OUT_DATA_W - MEM_W - TICK_W;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_UPDATE = 8'b0000_0010,
    ST_SUM    = 8'b0000_0100,
    ST_DRAIN  = 8'b0000_1000,
    ST_DLOAD  = 8'b0001_0000,
    ST_DRUN   = 8'b0010_0000,
    ST_DSTORE = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    OP_X    = 2'd0,
    OP_Y    = 2'd1,
    OP_Z    = 2'd2,
    OP_TIME = 2'd3
  } op_t;

  state_t state_r, state_nxt;
  op_t    op_r;

  // configuration registers
  logic [THR_W-1:0]  thr_x_r, thr_y_r, thr_z_r;
  logic [TICK_W-1:0] debounce_r;
  logic [TPM_W-1:0]  tpm_r;
  logic              det_en_r, avg_en_r;
  logic [CNT_W-1:0]  avg_cnt_r;
  logic              cfg_wr;
  reg_idx_t          reg_idx;

  // sample and detection state
  logic signed [SAMPLE_W-1:0] sx_r, sy_r, sz_r;
  logic [NOW_W-1:0]           now_r;
  logic signed [SAMPLE_W-1:0] prev_x_r, prev_y_r, prev_z_r;
  logic                       first_pend_r;
  logic [NOW_W-1:0]           last_move_r;
  logic                       move_r;

  // window
  logic [MEM_W-1:0]      win_mem [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] win_vld_r;
  logic [AW-1:0]         wp_r, wp_fix, wp_next;
  logic [AW:0]           wp_inc;
  logic                  mem_we;
  logic [AW-1:0]         rd_idx_r;
  logic [MEM_W-1:0]      rd_data_r;
  logic                  rd_vld_r;
  logic                  acc_en_r;
  logic [CW-1:0]         n_eff;
  logic [AW:0]           n_last;

  logic signed [SUM_W-1:0]    acc_x_r, acc_y_r, acc_z_r;
  logic signed [SAMPLE_W-1:0] ent_x, ent_y, ent_z;

  // detection logic
  logic signed [SAMPLE_W:0] dx, dy, dz;
  logic [SAMPLE_W:0]        ax, ay, az;
  logic [TIMER_BITS-1:0]    since;
  logic                     over, deb_ok, move_hit;

  // bit-serial divider
  logic [DW-1:0]           dvd_r;
  logic [TPM_W-1:0]        rem_r, dvs_r;
  logic [BIT_W-1:0]        bit_r;
  logic                    neg_r;
  logic [TPM_W+1:0]        trial;
  logic                    ge;
  logic signed [SUM_W-1:0] sel_sum;
  logic [SUM_W-1:0]        sel_mag;
  logic [QW-1:0]           q_ext;
  logic [SAMPLE_W-1:0]     q_avg;
  logic [TICK_W-1:0]       q_time;

  logic [SAMPLE_W-1:0] avg_x_r, avg_y_r, avg_z_r;
  logic [TICK_W-1:0]   elapsed_r;
  logic                out_load;
  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                out_move_r;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_x_r    <= '0;
      thr_y_r    <= '0;
      thr_z_r    <= '0;
      debounce_r <= '0;
      tpm_r      <= TPM_W'(1);
      det_en_r   <= 1'b0;
      avg_en_r   <= 1'b0;
      avg_cnt_r  <= CNT_W'(1);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_THR_X:    thr_x_r    <= cfg_pwdata[THR_W-1:0];
        REG_THR_Y:    thr_y_r    <= cfg_pwdata[THR_W-1:0];
        REG_THR_Z:    thr_z_r    <= cfg_pwdata[THR_W-1:0];
        REG_DEBOUNCE: debounce_r <= cfg_pwdata[TICK_W-1:0];
        REG_TPM:      tpm_r      <= cfg_pwdata[TPM_W-1:0];
        REG_DET_EN:   det_en_r   <= cfg_pwdata[0];
        REG_AVG_EN:   avg_en_r   <= cfg_pwdata[0];
        REG_AVG_CNT:  avg_cnt_r  <= cfg_pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THR_X:    cfg_prdata = CFG_DATA_W'(thr_x_r);
      REG_THR_Y:    cfg_prdata = CFG_DATA_W'(thr_y_r);
      REG_THR_Z:    cfg_prdata = CFG_DATA_W'(thr_z_r);
      REG_DEBOUNCE: cfg_prdata = CFG_DATA_W'(debounce_r);
      REG_TPM:      cfg_prdata = CFG_DATA_W'(tpm_r);
      REG_DET_EN:   cfg_prdata = CFG_DATA_W'(det_en_r);
      REG_AVG_EN:   cfg_prdata = CFG_DATA_W'(avg_en_r);
      REG_AVG_CNT:  cfg_prdata = CFG_DATA_W'(avg_cnt_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // Effective window count: zero reads as one, clamp to the window size.
  always_comb begin
    if (avg_cnt_r == '0) begin
      n_eff = CW'(1);
    end else if (int'(avg_cnt_r) > WINDOW_MAX) begin
      n_eff = CW'(WINDOW_MAX);
    end else begin
      n_eff = CW'(avg_cnt_r);
    end
  end
  assign n_last = (AW+1)'(n_eff) - (AW+1)'(1);

  // ---------------------------------------------------------------- control
  assign in_tready = (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_SUM;
      ST_SUM:    if ((AW+1)'(rd_idx_r) == n_last) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_DLOAD;
      ST_DLOAD:  state_nxt = ST_DRUN;
      ST_DRUN:   if (bit_r == '0) state_nxt = ST_DSTORE;
      ST_DSTORE: state_nxt = (op_r == OP_TIME) ? ST_DONE : ST_DLOAD;
      ST_DONE:   if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------- detection
  always_comb begin
    dx = (SAMPLE_W+1)'(sx_r) - (SAMPLE_W+1)'(prev_x_r);
    dy = (SAMPLE_W+1)'(sy_r) - (SAMPLE_W+1)'(prev_y_r);
    dz = (SAMPLE_W+1)'(sz_r) - (SAMPLE_W+1)'(prev_z_r);
    ax = dx[SAMPLE_W] ? (SAMPLE_W+1)'(-dx) : (SAMPLE_W+1)'(dx);
    ay = dy[SAMPLE_W] ? (SAMPLE_W+1)'(-dy) : (SAMPLE_W+1)'(dy);
    az = dz[SAMPLE_W] ? (SAMPLE_W+1)'(-dz) : (SAMPLE_W+1)'(dz);
    over = (ax > {1'b0, thr_x_r}) || (ay > {1'b0, thr_y_r}) || (az > {1'b0, thr_z_r});
  end

  // Ticks since the last movement, modulo the timer width; also the
  // dividend of the elapsed time once the movement update has landed.
  assign since    = TIMER_BITS'(now_r) - TIMER_BITS'(last_move_r);
  assign deb_ok   = CMP_W'(since) >= CMP_W'(debounce_r);
  assign move_hit = det_en_r && over && !first_pend_r && deb_ok;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      sx_r  <= in_tdata[SAMPLE_W-1:0];
      sy_r  <= in_tdata[2*SAMPLE_W-1:SAMPLE_W];
      sz_r  <= in_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
      now_r <= in_tdata[3*SAMPLE_W +: NOW_W];
    end
    if (state_r == ST_UPDATE) begin
      move_r <= move_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      prev_z_r     <= '0;
      first_pend_r <= 1'b1;
      last_move_r  <= '0;
    end else if ((state_r == ST_UPDATE) && det_en_r) begin
      prev_x_r     <= sx_r;
      prev_y_r     <= sy_r;
      prev_z_r     <= sz_r;
      first_pend_r <= 1'b0;
      if (move_hit) begin
        last_move_r <= now_r;
      end
    end
  end

  // ---------------------------------------------------------------- window
  // Wrap a stale write position before the write, then advance and wrap at n.
  assign wp_fix  = (int'(wp_r) >= WINDOW_MAX) ? '0 : wp_r;
  assign wp_inc  = (AW+1)'(wp_fix) + (AW+1)'(1);
  assign wp_next = (wp_inc >= (AW+1)'(n_eff)) ? '0 : wp_inc[AW-1:0];
  assign mem_we  = (state_r == ST_UPDATE) && avg_en_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[wp_fix] <= {sz_r, sy_r, sx_r};
    end
    rd_data_r <= win_mem[rd_idx_r];
    rd_vld_r  <= win_vld_r[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_vld_r <= '0;
      wp_r      <= '0;
      rd_idx_r  <= '0;
      acc_en_r  <= 1'b0;
    end else begin
      if (mem_we) begin
        win_vld_r[wp_fix] <= 1'b1;
        wp_r              <= wp_next;
      end
      // walk the read address across entries 0 .. n-1
      if (state_r == ST_SUM) begin
        rd_idx_r <= rd_idx_r + AW'(1);
      end else begin
        rd_idx_r <= '0;
      end
      acc_en_r <= (state_r == ST_SUM);
    end
  end

  // Entries never written read as zero.
  assign ent_x = rd_vld_r ? rd_data_r[SAMPLE_W-1:0] : '0;
  assign ent_y = rd_vld_r ? rd_data_r[2*SAMPLE_W-1:SAMPLE_W] : '0;
  assign ent_z = rd_vld_r ? rd_data_r[3*SAMPLE_W-1:2*SAMPLE_W] : '0;

  always_ff @(posedge clk) begin
    if (state_r == ST_UPDATE) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
      acc_z_r <= '0;
    end else if (acc_en_r) begin
      acc_x_r <= acc_x_r + SUM_W'(ent_x);
      acc_y_r <= acc_y_r + SUM_W'(ent_y);
      acc_z_r <= acc_z_r + SUM_W'(ent_z);
    end
  end

  // ---------------------------------------------------------------- divider
  always_comb begin
    case (op_r)
      OP_X:    sel_sum = acc_x_r;
      OP_Y:    sel_sum = acc_y_r;
      default: sel_sum = acc_z_r;
    endcase
    sel_mag = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
  end

  assign trial = {1'b0, rem_r, dvd_r[DW-1]} - {2'b00, dvs_r};
  assign ge    = !trial[TPM_W+1];

  // Quotient ends up in the dividend shift register.
  assign q_ext  = QW'(dvd_r);
  assign q_avg  = neg_r ? SAMPLE_W'(-dvd_r[SAMPLE_W-1:0]) : dvd_r[SAMPLE_W-1:0];
  assign q_time = (q_ext > QW'(ELAPSED_MAX)) ? ELAPSED_MAX : q_ext[TICK_W-1:0];

  always_ff @(posedge clk) begin
    case (state_r)
      ST_DLOAD: begin
        rem_r <= '0;
        bit_r <= BIT_W'(DW - 1);
        if (op_r == OP_TIME) begin
          dvd_r <= DW'(since);
          dvs_r <= (tpm_r == '0) ? TPM_W'(1) : tpm_r;
          neg_r <= 1'b0;
        end else begin
          dvd_r <= DW'(sel_mag);
          dvs_r <= TPM_W'(n_eff);
          neg_r <= sel_sum[SUM_W-1];
        end
      end
      ST_DRUN: begin
        // one quotient bit per cycle: shift in the dividend, try subtract
        rem_r <= ge ? trial[TPM_W-1:0] : {rem_r[TPM_W-2:0], dvd_r[DW-1]};
        dvd_r <= {dvd_r[DW-2:0], ge};
        bit_r <= bit_r - BIT_W'(1);
      end
      ST_DSTORE: begin
        case (op_r)
          OP_X:    avg_x_r <= q_avg;
          OP_Y:    avg_y_r <= q_avg;
          OP_Z:    avg_z_r <= q_avg;
          default: elapsed_r <= (last_move_r == '0) ? '0 : q_time;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_X;
    end else if (state_r == ST_UPDATE) begin
      op_r <= OP_X;
    end else if ((state_r == ST_DSTORE) && (op_r != OP_TIME)) begin
      op_r <= op_t'(op_r + 2'd1);
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {{PAD_W{1'b0}}, elapsed_r, avg_z_r, avg_y_r, avg_x_r};
      out_move_r <= move_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_move_r;

endmodule

// ----- rtl/core/amdma_chk.sv -----
// Port-level checker for the motion detector, bound to the top level.
module amdma_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [amdma_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [amdma_pkg::OUT_USER_W-1:0] out_tuser
);
  import amdma_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a sample in flight blocks the input
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a sample is in flight");

  // a movement result measures zero elapsed time
  a_move_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[OUT_ELAPSED_LSB +: TICK_W] == '0)
    else $error("movement result with nonzero elapsed time");

endmodule

bind accel_motion_detect_moving_avg_top amdma_chk u_amdma_chk (.*);

// ----- tb/motion_result_checker.sv -----
// Result checker for the motion detector: mirrors register writes, predicts and compares results.
`timescale 1ns / 100ps
module motion_result_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [amdma_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [amdma_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [amdma_pkg::OUT_USER_W-1:0] out_tuser,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [amdma_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [amdma_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                             cfg_pready,
  output int                               mismatch_count,
  output int                               results_owed
);
  import amdma_pkg::*;

  typedef struct packed {
    logic                       movement;
    logic signed [SAMPLE_W-1:0] avg_x;
    logic signed [SAMPLE_W-1:0] avg_y;
    logic signed [SAMPLE_W-1:0] avg_z;
    logic [TICK_W-1:0]          elapsed_ms;
  } motion_result_t;

  // Register copies
  logic [THR_W-1:0]  thr_x, thr_y, thr_z;
  logic [TICK_W-1:0] debounce;
  logic [TPM_W-1:0]  tick_rate;
  logic              detect_on, average_on;
  logic [CNT_W-1:0]  window_len;

  // Detector and window state
  logic signed [SAMPLE_W-1:0] last_x, last_y, last_z;
  logic                       awaiting_first;
  logic [TICK_W-1:0]          move_stamp;
  logic signed [SAMPLE_W-1:0] ring_x [WINDOW_MAX_DEF];
  logic signed [SAMPLE_W-1:0] ring_y [WINDOW_MAX_DEF];
  logic signed [SAMPLE_W-1:0] ring_z [WINDOW_MAX_DEF];
  int unsigned                ring_pos;

  motion_result_t pending_results[$];
  motion_result_t want, got;

  function automatic int abs_change(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic motion_result_t predict_motion_result(logic [IN_DATA_W-1:0] word);
    logic signed [SAMPLE_W-1:0] sx, sy, sz;
    logic [TICK_W-1:0]          now, gap;
    logic                       over;
    int                         n, sum_x, sum_y, sum_z;
    int unsigned                rate;
    motion_result_t             res;
    sx  = word[0 +: SAMPLE_W];
    sy  = word[SAMPLE_W +: SAMPLE_W];
    sz  = word[2*SAMPLE_W +: SAMPLE_W];
    now = word[3*SAMPLE_W +: TICK_W];
    res = '0;
    n   = (window_len == 0) ? 1 : int'(window_len);
    if (detect_on) begin
      gap  = now - move_stamp;
      over = abs_change(last_x, sx) > thr_x || abs_change(last_y, sy) > thr_y ||
             abs_change(last_z, sz) > thr_z;
      if (over && !awaiting_first && gap >= debounce) begin
        res.movement = 1'b1;
        move_stamp   = now;
      end
      awaiting_first = 1'b0;
      last_x = sx;
      last_y = sy;
      last_z = sz;
    end
    if (average_on) begin
      if (ring_pos >= WINDOW_MAX_DEF) ring_pos = 0;
      ring_x[ring_pos] = sx;
      ring_y[ring_pos] = sy;
      ring_z[ring_pos] = sz;
      ring_pos++;
      if (ring_pos >= n) ring_pos = 0;
    end
    sum_x = 0;
    sum_y = 0;
    sum_z = 0;
    for (int i = 0; i < n; i++) begin
      sum_x += ring_x[i];
      sum_y += ring_y[i];
      sum_z += ring_z[i];
    end
    res.avg_x = SAMPLE_W'(sum_x / n);
    res.avg_y = SAMPLE_W'(sum_y / n);
    res.avg_z = SAMPLE_W'(sum_z / n);
    // A stamp of zero reads as no movement seen yet
    if (move_stamp != 0) begin
      rate = (tick_rate == 0) ? 1 : tick_rate;
      gap  = now - move_stamp;
      res.elapsed_ms = TICK_W'(gap / rate);
    end
    return res;
  endfunction

  task automatic check_field(string label, logic [TICK_W-1:0] exp_v, logic [TICK_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      thr_x = '0; thr_y = '0; thr_z = '0;
      debounce = '0; tick_rate = 1;
      detect_on = 1'b0; average_on = 1'b0; window_len = 1;
      last_x = '0; last_y = '0; last_z = '0;
      awaiting_first = 1'b1;
      move_stamp = '0;
      for (int i = 0; i < WINDOW_MAX_DEF; i++) begin
        ring_x[i] = '0;
        ring_y[i] = '0;
        ring_z[i] = '0;
      end
      ring_pos = 0;
      pending_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[4:2]))
          REG_THR_X:    thr_x      = cfg_pwdata[THR_W-1:0];
          REG_THR_Y:    thr_y      = cfg_pwdata[THR_W-1:0];
          REG_THR_Z:    thr_z      = cfg_pwdata[THR_W-1:0];
          REG_DEBOUNCE: debounce   = cfg_pwdata[TICK_W-1:0];
          REG_TPM:      tick_rate  = cfg_pwdata[TPM_W-1:0];
          REG_DET_EN:   detect_on  = cfg_pwdata[0];
          REG_AVG_EN:   average_on = cfg_pwdata[0];
          REG_AVG_CNT:  window_len = cfg_pwdata[CNT_W-1:0];
          default: ;
        endcase
      end
      // Compare before predicting: a result never leaves on its own sample's edge
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                   $time, out_tdata, out_tuser);
        end else begin
          want = pending_results.pop_front();
          got.movement   = out_tuser[0];
          got.avg_x      = out_tdata[0 +: SAMPLE_W];
          got.avg_y      = out_tdata[SAMPLE_W +: SAMPLE_W];
          got.avg_z      = out_tdata[2*SAMPLE_W +: SAMPLE_W];
          got.elapsed_ms = out_tdata[OUT_ELAPSED_LSB +: TICK_W];
          check_field("movement", TICK_W'(want.movement), TICK_W'(got.movement));
          check_field("avg_x", TICK_W'(want.avg_x), TICK_W'(got.avg_x));
          check_field("avg_y", TICK_W'(want.avg_y), TICK_W'(got.avg_y));
          check_field("avg_z", TICK_W'(want.avg_z), TICK_W'(got.avg_z));
          check_field("elapsed_ms", want.elapsed_ms, got.elapsed_ms);
        end
      end
      if (in_tvalid && in_tready) pending_results.push_back(predict_motion_result(in_tdata));
    end
    results_owed = pending_results.size();
  end

endmodule

// ----- tb/testbench.sv -----
// Testbench top for the motion detector with moving average: stimulus, flow control, verdict.
`timescale 1ns / 100ps
module testbench;
  import amdma_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int mismatch_count;
  int results_owed;

  // Phase-wide flow control: no idle cycles on either side, one long receiver hold-off
  logic quiet_phase   = 1'b0;
  logic stall_request = 1'b0;

  // Random-walk state of the sensor model
  int                walk_x, walk_y, walk_z;
  int                walk_span;
  int                step_span;
  logic [TICK_W-1:0] timer_now;

  accel_motion_detect_moving_avg_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  motion_result_checker result_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #30_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off that lets the block
  // fill its output register and refuse new samples while the sender keeps offering
  initial begin
    int hold_left;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left     = 1500;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= quiet_phase || ($urandom_range(99) >= 31);
      end
    end
  end

  function automatic int clamp_axis(int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  function automatic logic [THR_W-1:0] pick_threshold();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 20) return '1;
    if (pick < 80) return THR_W'($urandom_range(300));
    return THR_W'($urandom);
  endfunction

  // Offer one sample; idle at random first, hold tvalid until the transfer.
  // Entered and left at a falling edge.
  task automatic push_sample(int x, int y, int z, logic [TICK_W-1:0] stamp);
    while (!quiet_phase && $urandom_range(99) < 31) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, stamp, SAMPLE_W'(z), SAMPLE_W'(y), SAMPLE_W'(x)};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Stop offering and wait until every outstanding result has been taken
  task automatic drain();
    in_tvalid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  // APB write: setup then access; psel stays up between back-to-back writes
  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
  endtask

  // Drain, then write the whole register set and release the bus
  task automatic apply_settings(logic [THR_W-1:0] tx, logic [THR_W-1:0] ty,
                                logic [THR_W-1:0] tz, logic [TICK_W-1:0] db,
                                logic [TPM_W-1:0] rate, logic det, logic avg,
                                logic [CNT_W-1:0] count);
    drain();
    write_reg(REG_THR_X, CFG_DATA_W'(tx));
    write_reg(REG_THR_Y, CFG_DATA_W'(ty));
    write_reg(REG_THR_Z, CFG_DATA_W'(tz));
    write_reg(REG_DEBOUNCE, CFG_DATA_W'(db));
    write_reg(REG_TPM, CFG_DATA_W'(rate));
    write_reg(REG_DET_EN, CFG_DATA_W'(det));
    write_reg(REG_AVG_EN, CFG_DATA_W'(avg));
    write_reg(REG_AVG_CNT, CFG_DATA_W'(count));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Random register set; window lengths stay mostly short to keep latency low
  task automatic draw_settings();
    logic [TICK_W-1:0] db;
    logic [TPM_W-1:0]  rate;
    logic [CNT_W-1:0]  count;
    int                pick;
    pick = $urandom_range(99);
    if (pick < 20)      db = '0;
    else if (pick < 70) db = TICK_W'($urandom_range(3000));
    else if (pick < 80) db = '1;
    else                db = TICK_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 10)      rate = '0;
    else if (pick < 20) rate = '1;
    else if (pick < 70) rate = TPM_W'($urandom_range(1, 100));
    else                rate = TPM_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 10)      count = '0;
    else if (pick < 20) count = '1;
    else if (pick < 70) count = CNT_W'($urandom_range(1, 8));
    else                count = CNT_W'($urandom_range(9, 64));
    walk_span = $urandom_range(1, 400);
    step_span = $urandom_range(10, 4000);
    apply_settings(pick_threshold(), pick_threshold(), pick_threshold(), db, rate,
                   $urandom_range(99) < 80, $urandom_range(99) < 80, count);
  endtask

  // Mostly a smooth sensor trace with an advancing timer; some pure noise
  task automatic feed_next_sample();
    if ($urandom_range(99) < 10) begin
      push_sample($urandom, $urandom, $urandom, TICK_W'($urandom));
    end else begin
      walk_x = clamp_axis(walk_x + int'($urandom_range(2 * walk_span)) - walk_span);
      walk_y = clamp_axis(walk_y + int'($urandom_range(2 * walk_span)) - walk_span);
      walk_z = clamp_axis(walk_z + int'($urandom_range(2 * walk_span)) - walk_span);
      if ($urandom_range(99) < 10) timer_now = TICK_W'($urandom);
      else                         timer_now += TICK_W'($urandom_range(step_span));
      push_sample(walk_x, walk_y, walk_z, timer_now);
    end
  endtask

  initial begin
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    walk_x      = 0;
    walk_y      = 0;
    walk_z      = 0;
    walk_span   = 1;
    step_span   = 1;
    timer_now   = '0;
    rst_n       = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: detection and averaging off, window reads as zero
    push_sample(-2048, 2047, -2048, '1);
    push_sample(2047, -2048, 2047, '0);

    // Zero thresholds and debounce, zero tick rate, zero window count
    apply_settings('0, '0, '0, '0, '0, 1'b1, 1'b1, '0);
    push_sample(0, 0, 0, 100);            // first sample with detection on: no event
    push_sample(5, 0, 0, 0);              // event at timer zero reads as none recorded
    push_sample(5, 0, 0, 7);              // no change: not strictly above threshold
    push_sample(-2048, 2047, -2048, 10);
    push_sample(2047, -2048, 2047, '1);   // full-scale swing on every axis
    push_sample(2047, -2048, 2047, 3);    // elapsed across timer wrap

    // Maximum thresholds, debounce, tick rate and window
    apply_settings('1, '1, '1, '1, '1, 1'b1, 1'b1, '1);
    push_sample(-2048, 2047, -2048, 50);  // change equals threshold: no event
    push_sample(0, 0, 0, 24'h800000);
    push_sample(2047, 2047, 2047, 24'hFFFFFE);

    // Short window with the ring position already past its end
    apply_settings(10, 20, 30, 100, 1000, 1'b1, 1'b1, 3);
    push_sample(2036, 2047, 2047, 1100);  // x one above threshold
    push_sample(2036, 2027, 2047, 1150);  // y exactly at threshold
    push_sample(2036, 2006, 2047, 1180);  // y over, inside debounce
    push_sample(2036, 2006, 2016, 1300);  // z over, debounce passed
    push_sample(2036, 2006, 2016, 5300);
    push_sample(-7, 3, -1, 5400);

    // Detection off: previous sample and stamp stay put
    apply_settings(10, 20, 30, 100, 1000, 1'b0, 1'b0, 3);
    push_sample(100, 100, 100, 9000);

    // Random phases; one runs without idling, one carries the long hold-off
    for (int phase = 0; phase < 12; phase++) begin
      draw_settings();
      quiet_phase = (phase == 3);
      if (phase == 1) stall_request = 1'b1;
      for (int k = 0; k < 120; k++) feed_next_sample();
    end

    drain();
    // Let any stray result surface before the verdict
    repeat (400) @(negedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
